/* src/csap_pkg.sv */
package csap_pkg;

  localparam int RUN_SLOTS  = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int ID_BITS    = 8;

  localparam int RUN_IW  = $clog2(RUN_SLOTS);
  localparam int WAIT_IW = $clog2(WAIT_DEPTH);
  localparam int RCNT_W  = $clog2(RUN_SLOTS + 1);
  localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
  localparam int MAXD    = (RUN_SLOTS > WAIT_DEPTH) ? RUN_SLOTS : WAIT_DEPTH;
  localparam int SCAN_W  = $clog2(MAXD + 1);
  localparam int POS_W   = $clog2(MAXD);

  // input kinds
  localparam logic [3:0] K_ACCEPT  = 4'd0;
  localparam logic [3:0] K_CONNECT = 4'd1;
  localparam logic [3:0] K_ADD     = 4'd2;
  localparam logic [3:0] K_SWITCH  = 4'd3;
  localparam logic [3:0] K_FREED   = 4'd4;
  localparam logic [3:0] K_CANCEL  = 4'd5;
  localparam logic [3:0] K_STATUS  = 4'd6;
  localparam logic [3:0] K_TICK    = 4'd7;
  localparam logic [3:0] K_LIMITS  = 4'd8;

  // result actions
  localparam logic [3:0] A_ACK       = 4'd0;
  localparam logic [3:0] A_ACC_GRANT = 4'd1;
  localparam logic [3:0] A_ACC_REF   = 4'd2;
  localparam logic [3:0] A_GRANT     = 4'd3;
  localparam logic [3:0] A_QUEUED    = 4'd4;
  localparam logic [3:0] A_PREEMPT   = 4'd5;
  localparam logic [3:0] A_NO_VICTIM = 4'd6;
  localparam logic [3:0] A_RELEASED  = 4'd7;
  localparam logic [3:0] A_DISARMED  = 4'd8;
  localparam logic [3:0] A_QFULL     = 4'd9;

  // config register indexes
  localparam logic REG_SOFT = 1'b0;
  localparam logic REG_HARD = 1'b1;

  typedef struct packed {
    logic               queued;
    logic               empty;
    logic               close;
    logic [ID_BITS-1:0] id;
  } run_entry_t;

  typedef struct packed {
    logic latch;
    logic step;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_last;
  } dp_sts_t;

endpackage

/* src/connection_slot_admission_preempt.sv */
// channel   | dir | handshake                 | contents
// s_axis    | in  | tvalid/tready             | one request transaction
// m_axis    | out | tvalid/tready, tlast      | one result transaction
// apb       | in  | psel/penable, pready = 1  | soft_limit @0x0, hard_limit @0x4
//
// an item is latched, scans one list entry per step, executes and returns
// its result (switch, status, tick, freed with was_running scan the running
// list, cancel scans the wait queue); limit changes execute again per grant.
// reset clears counts, timer and control; list contents need no clearing.
// a stalled result holds the block; no new transaction is taken until the
// last result of the current one has been taken.
module connection_slot_admission_preempt import csap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // conn_id[7:0], other_id[15:8], was_running[16], can_close[17],
  // empty_buffers[18], has_queued[19], zero[23:20]
  input  logic [23:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // target_id[7:0], slots_used[12:8], waiting_count[17:13], timer_armed[18], zero[23:19]
  output logic [23:0] m_axis_tdata,
  // action[3:0]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]         soft_q, hard_q;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [ID_BITS-1:0] target;
  logic [4:0]         used, waiting;
  logic               timer;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HARD) ? {27'd0, hard_q} : {27'd0, soft_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q <= 5'd8;
      hard_q <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SOFT) soft_q <= pwdata[4:0];
      else hard_q <= pwdata[4:0];
    end
  end

  csap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csap_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .soft_i        (soft_q),
    .hard_i        (hard_q),
    .kind_i        (s_axis_tuser),
    .id_i          (s_axis_tdata[ID_BITS-1:0]),
    .oid_i         (s_axis_tdata[8 +: ID_BITS]),
    .was_running_i (s_axis_tdata[16]),
    .flags_i       ({s_axis_tdata[19], s_axis_tdata[18], s_axis_tdata[17]}),
    .action_o      (m_axis_tuser),
    .target_o      (target),
    .used_o        (used),
    .waiting_o     (waiting),
    .timer_o       (timer),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, timer, waiting, used, 8'(target)};

endmodule

/* src/csap_ctrl.sv */
module csap_ctrl import csap_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_EXEC;
        else cmd_o.step = 1'b1;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        // limit changes come back for the next grant
        if (out_ready_i) state_d = sts_i.out_last ? S_IDLE : S_EXEC;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output open together");
  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !sts_i.out_last) |=> (state_q == S_EXEC))
    else $error("missing follow-up result");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> (state_q == S_SCAN))
    else $error("accepted transaction not scanned");
`endif

endmodule

/* src/csap_dp.sv */
module csap_dp import csap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [4:0]         soft_i,
  input  logic [4:0]         hard_i,
  input  logic [3:0]         kind_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic [ID_BITS-1:0] oid_i,
  input  logic               was_running_i,
  input  logic [2:0]         flags_i,
  output logic [3:0]         action_o,
  output logic [ID_BITS-1:0] target_o,
  output logic [4:0]         used_o,
  output logic [4:0]         waiting_o,
  output logic               timer_o,
  output logic               last_o
);

  logic [3:0]         kind_q;
  logic [ID_BITS-1:0] id_q, oid_q;
  logic               wr_q;
  logic [2:0]         flags_q;

  logic [4:0]         used_q, used_d;
  logic [RCNT_W-1:0]  rcnt_q, rcnt_d;
  logic [WCNT_W-1:0]  wcnt_q, wcnt_d;
  logic               timer_q, timer_d;
  run_entry_t         run_q [RUN_SLOTS];
  run_entry_t         run_d [RUN_SLOTS];
  logic [ID_BITS-1:0] wfifo_q [WAIT_DEPTH];
  logic [ID_BITS-1:0] wfifo_d [WAIT_DEPTH];

  // scan state
  logic [SCAN_W-1:0]  idx_q;
  logic [POS_W-1:0]   pos_q;
  logic               found_q;
  logic               f1_q, f2_q, f3_q;
  logic [ID_BITS-1:0] v1_q, v2_q, v3_q;

  logic [3:0]         act_d;
  logic [ID_BITS-1:0] tgt_d;
  logic               last_d;

  logic               run_scan, wait_scan;
  logic [SCAN_W-1:0]  scan_lim;
  run_entry_t         cur_run;
  logic [ID_BITS-1:0] cur_wait;
  logic [4:0]         used_inc;
  logic               pressure;

  assign run_scan  = (kind_q == K_SWITCH) || (kind_q == K_STATUS) || (kind_q == K_TICK) ||
                     ((kind_q == K_FREED) && wr_q);
  assign wait_scan = (kind_q == K_CANCEL);
  assign scan_lim  = run_scan ? SCAN_W'(rcnt_q) : (wait_scan ? SCAN_W'(wcnt_q) : '0);
  assign cur_run   = run_q[idx_q[RUN_IW-1:0]];
  assign cur_wait  = wfifo_q[idx_q[WAIT_IW-1:0]];
  assign sts_o.scan_done = (idx_q >= scan_lim);
  assign sts_o.out_last  = last_o;
  assign used_inc  = used_q + 5'd1;
  assign pressure  = (used_q > soft_i) || ((used_q == soft_i) && (wcnt_q != '0));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      id_q    <= id_i;
      oid_q   <= oid_i;
      wr_q    <= was_running_i;
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      f1_q    <= 1'b0;
      f2_q    <= 1'b0;
      f3_q    <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
      if (run_scan) begin
        if (!found_q && (cur_run.id == id_q)) begin
          found_q <= 1'b1;
          pos_q   <= POS_W'(idx_q);
        end
        if (cur_run.close && cur_run.empty && !cur_run.queued && !f1_q) begin
          f1_q <= 1'b1;
          v1_q <= cur_run.id;
        end
        if (cur_run.close && cur_run.empty && cur_run.queued && !f2_q) begin
          f2_q <= 1'b1;
          v2_q <= cur_run.id;
        end
        if (cur_run.close && !cur_run.empty && !f3_q) begin
          f3_q <= 1'b1;
          v3_q <= cur_run.id;
        end
      end else if (!found_q && (cur_wait == id_q)) begin
        found_q <= 1'b1;
        pos_q   <= POS_W'(idx_q);
      end
    end
  end

  always_comb begin
    used_d  = used_q;
    rcnt_d  = rcnt_q;
    wcnt_d  = wcnt_q;
    timer_d = timer_q;
    run_d   = run_q;
    wfifo_d = wfifo_q;
    act_d   = A_ACK;
    tgt_d   = '0;
    last_d  = 1'b1;
    case (kind_q)
      K_ACCEPT: begin
        tgt_d = id_q;
        if (used_q < hard_i) begin
          used_d = used_inc;
          if (used_inc > soft_i) timer_d = 1'b1;
          act_d = A_ACC_GRANT;
        end else begin
          act_d = A_ACC_REF;
        end
      end
      K_CONNECT: begin
        tgt_d = id_q;
        if (used_q < soft_i) begin
          used_d = used_inc;
          act_d  = A_GRANT;
        end else if (wcnt_q >= WCNT_W'(WAIT_DEPTH)) begin
          act_d = A_QFULL;
        end else begin
          wfifo_d[wcnt_q[WAIT_IW-1:0]] = id_q;
          wcnt_d  = wcnt_q + 1'b1;
          timer_d = 1'b1;
          act_d   = A_QUEUED;
        end
      end
      K_ADD: begin
        if (rcnt_q < RCNT_W'(RUN_SLOTS)) begin
          run_d[rcnt_q[RUN_IW-1:0]] = {flags_q, id_q};
          rcnt_d = rcnt_q + 1'b1;
        end
      end
      K_SWITCH: begin
        if (found_q) run_d[pos_q[RUN_IW-1:0]] = {flags_q, oid_q};
      end
      K_STATUS: begin
        if (found_q) run_d[pos_q[RUN_IW-1:0]] = {flags_q, run_q[pos_q[RUN_IW-1:0]].id};
      end
      K_FREED: begin
        if (wr_q && found_q) begin
          for (int i = 0; i < RUN_SLOTS - 1; i++) begin
            if (POS_W'(i) >= pos_q) run_d[i] = run_q[i + 1];
          end
          rcnt_d = rcnt_q - 1'b1;
        end
        if ((used_q <= soft_i) && (wcnt_q != '0)) begin
          for (int i = 0; i < WAIT_DEPTH - 1; i++) wfifo_d[i] = wfifo_q[i + 1];
          wcnt_d = wcnt_q - 1'b1;
          act_d  = A_GRANT;
          tgt_d  = wfifo_q[0];
        end else begin
          if (used_q != '0) used_d = used_q - 5'd1;
          act_d = A_RELEASED;
          tgt_d = id_q;
        end
      end
      K_CANCEL: begin
        if (found_q) begin
          for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
            if (POS_W'(i) >= pos_q) wfifo_d[i] = wfifo_q[i + 1];
          end
          wcnt_d = wcnt_q - 1'b1;
        end
      end
      K_TICK: begin
        if (!timer_q) begin
          act_d = A_ACK;
        end else if (pressure) begin
          priority if (f1_q) begin
            act_d = A_PREEMPT;
            tgt_d = v1_q;
          end else if (f2_q) begin
            act_d = A_PREEMPT;
            tgt_d = v2_q;
          end else if (f3_q) begin
            act_d = A_PREEMPT;
            tgt_d = v3_q;
          end else begin
            act_d = A_NO_VICTIM;
          end
        end else begin
          timer_d = 1'b0;
          act_d   = A_DISARMED;
        end
      end
      K_LIMITS: begin
        // one grant per pass until the soft limit is reached
        if (used_q > soft_i) timer_d = 1'b1;
        if ((used_q < soft_i) && (wcnt_q != '0)) begin
          for (int i = 0; i < WAIT_DEPTH - 1; i++) wfifo_d[i] = wfifo_q[i + 1];
          wcnt_d = wcnt_q - 1'b1;
          used_d = used_inc;
          act_d  = A_GRANT;
          tgt_d  = wfifo_q[0];
          last_d = 1'b0;
        end else if (used_q < soft_i) begin
          timer_d = 1'b0;
          act_d   = A_DISARMED;
        end
      end
      default: act_d = A_ACK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      rcnt_q  <= '0;
      wcnt_q  <= '0;
      timer_q <= 1'b0;
    end else if (cmd_i.exec) begin
      used_q  <= used_d;
      rcnt_q  <= rcnt_d;
      wcnt_q  <= wcnt_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      run_q     <= run_d;
      wfifo_q   <= wfifo_d;
      action_o  <= act_d;
      target_o  <= tgt_d;
      used_o    <= used_d;
      waiting_o <= 5'(wcnt_d);
      timer_o   <= timer_d;
      last_o    <= last_d;
    end
  end

`ifndef ASSERT_OFF
  a_wait_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= WCNT_W'(WAIT_DEPTH)) else $error("wait count overflow");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RCNT_W'(RUN_SLOTS)) else $error("running count overflow");
`endif

endmodule

/* dv/tb_connection_slot_admission_preempt.sv */
module tb_connection_slot_admission_preempt;
  import csap_pkg::*;

  typedef struct {
    logic [3:0] kind;
    logic [7:0] cid;
    logic [7:0] oid;
    logic       was_run;
    logic       can_close;
    logic       empty_buf;
    logic       has_q;
  } req_t;

  typedef struct {
    logic [3:0] action;
    logic [7:0] target;
    logic [4:0] used;
    logic [4:0] waiting;
    logic       armed;
    logic       last;
  } slot_res_t;

  typedef struct {
    req_t       rq;
    bit         chk;
    logic [3:0] act;
  } dir_row_t;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  connection_slot_admission_preempt uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted block state
  logic [4:0]  soft_q, hard_q, used_q, wcnt_q;
  logic        timer_q;
  logic        rv_q [RUN_SLOTS];
  run_entry_t  re_q [RUN_SLOTS];
  logic [7:0]  wq_q [WAIT_DEPTH];

  slot_res_t   expected_q [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  function automatic void push_result(logic [3:0] a, logic [7:0] t, logic l);
    slot_res_t r;
    r.action = a; r.target = t; r.used = used_q; r.waiting = wcnt_q;
    r.armed = timer_q; r.last = l;
    expected_q.push_back(r);
  endfunction

  function automatic int running_count();
    int n = 0;
    while (n < RUN_SLOTS && rv_q[n]) n++;
    return n;
  endfunction

  function automatic int running_find(logic [7:0] id);
    int n = running_count();
    for (int i = 0; i < n; i++)
      if (re_q[i].id == id) return i;
    return -1;
  endfunction

  function automatic logic [7:0] pop_waiter();
    logic [7:0] id = wq_q[0];
    for (int i = 0; i < WAIT_DEPTH - 1; i++) wq_q[i] = wq_q[i + 1];
    wcnt_q--;
    return id;
  endfunction

  // works out every result that one request causes
  function automatic void predict_slots(req_t r);
    run_entry_t fl;
    int p, n, c1, c2, c3;
    bit cleared;
    fl.close = r.can_close; fl.empty = r.empty_buf; fl.queued = r.has_q; fl.id = '0;
    case (r.kind)
      K_ACCEPT: begin
        if (used_q < hard_q) begin
          used_q++;
          if (used_q > soft_q) timer_q = 1'b1;
          push_result(A_ACC_GRANT, r.cid, 1'b1);
        end else push_result(A_ACC_REF, r.cid, 1'b1);
      end
      K_CONNECT: begin
        if (used_q < soft_q) begin
          used_q++;
          push_result(A_GRANT, r.cid, 1'b1);
        end else if (wcnt_q >= WAIT_DEPTH) begin
          push_result(A_QFULL, r.cid, 1'b1);
        end else begin
          wq_q[wcnt_q[WAIT_IW-1:0]] = r.cid;
          wcnt_q++;
          timer_q = 1'b1;
          push_result(A_QUEUED, r.cid, 1'b1);
        end
      end
      K_ADD: begin
        n = running_count();
        if (n < RUN_SLOTS) begin
          fl.id = r.cid; re_q[n] = fl; rv_q[n] = 1'b1;
        end
        push_result(A_ACK, '0, 1'b1);
      end
      K_SWITCH: begin
        p = running_find(r.cid);
        if (p >= 0) begin
          fl.id = r.oid; re_q[p] = fl;
        end
        push_result(A_ACK, '0, 1'b1);
      end
      K_FREED: begin
        if (r.was_run) begin
          p = running_find(r.cid);
          if (p >= 0) begin
            n = running_count();
            for (int i = p; i + 1 < n; i++) re_q[i] = re_q[i + 1];
            rv_q[n - 1] = 1'b0;
          end
        end
        if (used_q <= soft_q && wcnt_q > 0) begin
          logic [7:0] nx = pop_waiter();
          push_result(A_GRANT, nx, 1'b1);
        end else begin
          if (used_q > 0) used_q--;
          push_result(A_RELEASED, r.cid, 1'b1);
        end
      end
      K_CANCEL: begin
        for (int i = 0; i < wcnt_q; i++)
          if (wq_q[i] == r.cid) begin
            for (int j = i; j < WAIT_DEPTH - 1; j++) wq_q[j] = wq_q[j + 1];
            wcnt_q--;
            break;
          end
        push_result(A_ACK, '0, 1'b1);
      end
      K_STATUS: begin
        p = running_find(r.cid);
        if (p >= 0) begin
          fl.id = re_q[p].id; re_q[p] = fl;
        end
        push_result(A_ACK, '0, 1'b1);
      end
      K_TICK: begin
        if (!timer_q) push_result(A_ACK, '0, 1'b1);
        else if (used_q > soft_q || (used_q == soft_q && wcnt_q > 0)) begin
          // idle and drained first, then drained, then merely closable
          c1 = -1; c2 = -1; c3 = -1;
          n = running_count();
          for (int i = 0; i < n; i++) begin
            if (!re_q[i].close) continue;
            if (re_q[i].empty) begin
              if (!re_q[i].queued) begin c1 = i; break; end
              if (c2 < 0) c2 = i;
            end else if (c3 < 0) c3 = i;
          end
          if (c1 < 0) c1 = c2;
          if (c1 < 0) c1 = c3;
          if (c1 >= 0) push_result(A_PREEMPT, re_q[c1].id, 1'b1);
          else push_result(A_NO_VICTIM, '0, 1'b1);
        end else begin
          timer_q = 1'b0;
          push_result(A_DISARMED, '0, 1'b1);
        end
      end
      K_LIMITS: begin
        cleared = 0;
        if (used_q > soft_q) timer_q = 1'b1;
        while (used_q < soft_q) begin
          if (wcnt_q > 0) begin
            logic [7:0] nx = pop_waiter();
            used_q++;
            push_result(A_GRANT, nx, 1'b0);
          end else begin
            timer_q = 1'b0;
            cleared = 1;
            break;
          end
        end
        push_result(cleared ? A_DISARMED : A_ACK, '0, 1'b1);
      end
      default: push_result(A_ACK, '0, 1'b1);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      slot_res_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result act=%0d data=%h", $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tuser !== e.action || m_axis_tdata[7:0] !== e.target ||
            m_axis_tdata[12:8] !== e.used || m_axis_tdata[17:13] !== e.waiting ||
            m_axis_tdata[18] !== e.armed || m_axis_tdata[23:19] !== 5'd0 ||
            m_axis_tlast !== e.last) begin
          $display("%0t: mismatch exp act=%0d tgt=%h used=%0d wait=%0d tmr=%b last=%b",
                   $time, e.action, e.target, e.used, e.waiting, e.armed, e.last);
          $display("%0t:          got act=%0d tgt=%h used=%0d wait=%0d tmr=%b last=%b",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8],
                   m_axis_tdata[17:13], m_axis_tdata[18], m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i)
    m_axis_tready = !rst_ni ? 1'b0 : ($urandom_range(99) >= stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress, %0d results still pending", $time, expected_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_req(req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = r.kind;
    s_axis_tdata  = {4'd0, r.has_q, r.empty_buf, r.can_close, r.was_run, r.oid, r.cid};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_slots(r);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [4:0] val);
    drain();
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = {27'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (idx == REG_SOFT) soft_q = val; else hard_q = val;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic req_t mk(logic [3:0] k, logic [7:0] c, logic [7:0] o,
                              logic w, logic cc, logic eb, logic hq);
    req_t r;
    r.kind = k; r.cid = c; r.oid = o; r.was_run = w;
    r.can_close = cc; r.empty_buf = eb; r.has_q = hq;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int w = $urandom_range(99);
    logic [3:0] k;
    if      (w < 12) k = K_ACCEPT;
    else if (w < 30) k = K_CONNECT;
    else if (w < 44) k = K_ADD;
    else if (w < 50) k = K_SWITCH;
    else if (w < 66) k = K_FREED;
    else if (w < 72) k = K_CANCEL;
    else if (w < 80) k = K_STATUS;
    else if (w < 92) k = K_TICK;
    else if (w < 97) k = K_LIMITS;
    else k = 4'($urandom_range(15, 9));
    // a small id pool makes lookups hit most of the time
    r = mk(k, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
           ($urandom_range(1)) ? 8'($urandom) : 8'($urandom_range(7)),
           $urandom_range(3) != 0, 1'($urandom), 1'($urandom), 1'($urandom));
    return r;
  endfunction

  dir_row_t dir_tab [$];
  localparam int SPLIT = 9;
  int idle_mix [5][2] = '{'{0, 0}, '{45, 0}, '{0, 45}, '{30, 30}, '{45, 45}};
  int soft_set [5] = '{8, 0, 16, 3, 5};
  int hard_set [5] = '{16, 0, 16, 1, 10};

  initial begin
    soft_q = 5'd8; hard_q = 5'd16; used_q = '0; wcnt_q = '0; timer_q = 1'b0;
    for (int i = 0; i < RUN_SLOTS; i++) begin rv_q[i] = 1'b0; re_q[i] = '0; end
    for (int i = 0; i < WAIT_DEPTH; i++) wq_q[i] = '0;

    // first part at reset limits, second part at soft 1 / hard 2
    dir_tab = '{
      '{mk(K_TICK,    8'h00, 8'h00, 0, 0, 0, 0), 1, A_ACK},
      '{mk(K_FREED,   8'h12, 8'h00, 1, 0, 0, 0), 1, A_RELEASED},
      '{mk(4'd15,     8'hff, 8'hff, 1, 1, 1, 1), 1, A_ACK},
      '{mk(K_STATUS,  8'h77, 8'h00, 0, 1, 1, 1), 1, A_ACK},
      '{mk(K_ACCEPT,  8'hff, 8'h00, 0, 0, 0, 0), 1, A_ACC_GRANT},
      '{mk(K_ADD,     8'hff, 8'h00, 0, 1, 1, 0), 1, A_ACK},
      '{mk(K_ADD,     8'h00, 8'h00, 0, 1, 0, 0), 1, A_ACK},
      '{mk(K_SWITCH,  8'h00, 8'ha5, 0, 1, 1, 1), 1, A_ACK},
      '{mk(K_CONNECT, 8'h5a, 8'h00, 0, 0, 0, 0), 1, A_GRANT},
      '{mk(K_CONNECT, 8'h33, 8'h00, 0, 0, 0, 0), 1, A_QUEUED},
      '{mk(K_TICK,    8'h00, 8'h00, 0, 0, 0, 0), 1, A_PREEMPT},
      '{mk(K_ACCEPT,  8'h44, 8'h00, 0, 0, 0, 0), 1, A_ACC_REF},
      '{mk(K_CANCEL,  8'h33, 8'h00, 0, 0, 0, 0), 1, A_ACK},
      '{mk(K_CONNECT, 8'h34, 8'h00, 0, 0, 0, 0), 1, A_QUEUED},
      '{mk(K_STATUS,  8'ha5, 8'h00, 0, 0, 0, 0), 0, A_ACK},
      '{mk(K_FREED,   8'hff, 8'h00, 1, 0, 0, 0), 1, A_RELEASED},
      '{mk(K_FREED,   8'h5a, 8'h00, 0, 0, 0, 0), 1, A_GRANT},
      '{mk(K_TICK,    8'h00, 8'h00, 0, 0, 0, 0), 1, A_DISARMED},
      '{mk(K_LIMITS,  8'h00, 8'h00, 0, 0, 0, 0), 0, A_ACK}
    };

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < dir_tab.size(); i++) begin
      if (i == SPLIT) begin
        write_limit(REG_SOFT, 5'd1);
        write_limit(REG_HARD, 5'd2);
      end
      send_req(dir_tab[i].rq);
      if (dir_tab[i].chk && expected_q[$].action !== dir_tab[i].act) begin
        $display("%0t: row %0d predicted act=%0d, table says %0d",
                 $time, i, expected_q[$].action, dir_tab[i].act);
        errors++;
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(REG_SOFT, 5'(soft_set[ph]));
      write_limit(REG_HARD, 5'(hard_set[ph]));
      send_idle_pct = idle_mix[ph][0];
      stall_pct     = idle_mix[ph][1];
      for (int j = 0; j < 52; j++) begin
        if (ph == 2 && j == 26) begin
          // hold off until everything outstanding has come back
          s_axis_tvalid = 1'b0;
          while (expected_q.size() != 0) @(negedge clk_i);
        end
        send_req(rand_req());
      end
    end

    stall_pct = 0;
    drain();
    $display("%0d requests and %0d results across 7 limit settings and 5 idle mixes",
             n_items, n_results);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* connection_slot_admission_preempt.f */
src/csap_pkg.sv
src/csap_ctrl.sv
src/csap_dp.sv
src/connection_slot_admission_preempt.sv
dv/tb_connection_slot_admission_preempt.sv
